// File: rtl/prpi_pkg.sv
`default_nettype none
package prpi_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_WR_OFFSET = 2'd0;
  localparam logic [1:0] CMD_WR_TARGET = 2'd1;
  localparam logic [1:0] CMD_RUN       = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_DAMPING       = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;
  localparam logic [1:0] REG_ITER_LIMIT    = 2'd3;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_RANK = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] slot;
    logic [13:0] datum;
    logic        in_range;
  } prpi_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } prpi_qstat_t;

  typedef struct packed {
    logic [15:0] damping;
    logic [31:0] threshold;
    logic [15:0] limit;
  } prpi_cfg_t;

endpackage
`default_nettype wire

// File: rtl/prpi_fifo.sv
`default_nettype none
module prpi_fifo
  import prpi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire prpi_cmd_t   push_data,
  input  wire logic        pop,
  output prpi_cmd_t        head,
  output prpi_qstat_t      qstat
);

  prpi_cmd_t        q_mem [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  assign head        = q_mem[rd_ptr_r];
  assign qstat.full  = (cnt_r == (QPW+1)'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

// File: rtl/prpi_front.sv
`default_nettype none
module prpi_front
  import prpi_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192,
  parameter int VW           = 11
) (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_command,
  input  wire logic [13:0]   in_slot,
  input  wire logic [13:0]   in_datum,
  input  wire logic [VW-1:0] n_active,
  input  wire prpi_qstat_t   qstat,
  output logic               push,
  output prpi_cmd_t          entry
);

  logic keep;

  // writes outside the stores are taken and dropped here
  always_comb begin
    case (in_command)
      CMD_WR_OFFSET: keep = (32'(in_slot) <= 32'(MAX_VERTICES));
      CMD_WR_TARGET: keep = (32'(in_slot) < 32'(MAX_EDGES));
      default:       keep = 1'b1;
    endcase
  end

  assign in_ready       = !qstat.full;
  assign push           = in_valid && !qstat.full && keep;
  assign entry.op       = in_command;
  assign entry.slot     = in_slot;
  assign entry.datum    = in_datum;
  assign entry.in_range = (32'(in_slot) < 32'(n_active));

endmodule
`default_nettype wire

// File: rtl/prpi_div.sv
`default_nettype none
module prpi_div #(
  parameter int RW  = 32,
  parameter int DVW = 14
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [RW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                done,
  output logic [RW-1:0]       quotient
);

  localparam int CNTW = $clog2(RW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [DVW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]     quo_r, quo_nxt;
  logic [DVW-1:0]    dvs_r, dvs_nxt;
  logic [DVW:0]      shifted;
  logic [DVW:0]      trial;
  logic              ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    shifted  = {rem_r, quo_r[RW-1]};
    ge       = (shifted >= {1'b0, dvs_r});
    trial    = ge ? shifted - {1'b0, dvs_r} : shifted;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = trial[DVW-1:0];
      quo_nxt = {quo_r[RW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(RW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: rtl/prpi_engine.sv
`default_nettype none
module prpi_engine
  import prpi_pkg::*;
#(
  parameter int MAX_VERTICES   = 1024,
  parameter int MAX_EDGES      = 8192,
  parameter int RANK_FRAC_BITS = 31,
  parameter int VW             = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire prpi_cmd_t     q_head,
  input  wire prpi_qstat_t   qstat,
  output logic               pop,
  input  wire logic [VW-1:0] n_active,
  input  wire prpi_cfg_t     cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [15:0]        out_iterations_done,
  output logic [31:0]        out_rank_value
);

  localparam int RW   = RANK_FRAC_BITS + 1;
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int OAW  = $clog2(MAX_VERTICES + 1);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DVW  = (VW > EW) ? VW : EW;
  localparam int CW   = ((RW > 32) ? RW : 32) + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD     = 5'd1;
  localparam logic [4:0] S_EMIT   = 5'd2;
  localparam logic [4:0] S_W_INIT = 5'd3;
  localparam logic [4:0] S_W_BASE = 5'd4;
  localparam logic [4:0] S_INIT   = 5'd5;
  localparam logic [4:0] S_CLR    = 5'd6;
  localparam logic [4:0] S_OFF0   = 5'd7;
  localparam logic [4:0] S_SRC    = 5'd8;
  localparam logic [4:0] S_SHARE  = 5'd9;
  localparam logic [4:0] S_EDGE_B = 5'd10;
  localparam logic [4:0] S_EDGE_C = 5'd11;
  localparam logic [4:0] S_NEXTV  = 5'd12;
  localparam logic [4:0] S_UPD_A  = 5'd13;
  localparam logic [4:0] S_UPD_B  = 5'd14;
  localparam logic [4:0] S_UPD_C  = 5'd15;
  localparam logic [4:0] S_ITER   = 5'd16;

  // stores
  logic [13:0]   off_mem  [MAX_VERTICES + 1];
  logic [13:0]   tgt_mem  [MAX_EDGES];
  logic [RW-1:0] rank_mem [MAX_VERTICES];
  logic [RW-1:0] sum_mem  [MAX_VERTICES];

  logic           off_we, off_re;
  logic [OAW-1:0] off_wa, off_ra;
  logic [13:0]    off_wd, off_rd_r;
  logic           tgt_we, tgt_re;
  logic [EAW-1:0] tgt_wa, tgt_ra;
  logic [13:0]    tgt_wd, tgt_rd_r;
  logic           rank_we, rank_re;
  logic [VAW-1:0] rank_wa, rank_ra;
  logic [RW-1:0]  rank_wd, rank_rd_r;
  logic           sum_we, sum_re;
  logic [VAW-1:0] sum_wa, sum_ra;
  logic [RW-1:0]  sum_wd, sum_rd_r;

  logic [4:0]     state_r, state_nxt;
  logic [VW-1:0]  v_r, v_nxt;
  logic [VW-1:0]  hw_r, hw_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic [EW-1:0]  row_start_r, row_start_nxt;
  logic [EW-1:0]  row_end_r, row_end_nxt;
  logic [RW-1:0]  init_r, init_nxt;
  logic [RW-1:0]  base_r, base_nxt;
  logic [RW-1:0]  share_r, share_nxt;
  logic [VAW-1:0] t_r, t_nxt;
  logic [RW+15:0] prod_r, prod_nxt;
  logic [RW-1:0]  old_r, old_nxt;
  logic [RW-1:0]  upd_r, upd_nxt;
  logic [31:0]    delta_r, delta_nxt;
  logic [15:0]    iter_r, iter_nxt;
  logic [13:0]    slot_r, slot_nxt;
  logic           inr_r, inr_nxt;
  logic           res_kind_r, res_kind_nxt;
  logic [15:0]    res_iter_r, res_iter_nxt;
  logic [31:0]    res_rank_r, res_rank_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic [15:0]    out_iter_r, out_iter_nxt;
  logic [31:0]    out_rank_r, out_rank_nxt;

  logic           div_start, div_done;
  logic [RW-1:0]  div_dividend, div_q;
  logic [DVW-1:0] div_divisor;

  logic [RW-1:0]  one_val, base_num;
  logic [EW-1:0]  clamp_rd;
  logic [EW-1:0]  e_inc;
  logic           v_last;
  logic [RW:0]    sacc, uacc;
  logic [RW-1:0]  diff;
  logic [CW-1:0]  dacc;
  logic [15:0]    iter_inc;

  prpi_div #(
    .RW  (RW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    one_val  = RW'(1) << RANK_FRAC_BITS;
    base_num = RW'(17'(17'h10000 - 17'(cfg.damping))) << (RANK_FRAC_BITS - 16);
    clamp_rd = (32'(off_rd_r) > 32'(MAX_EDGES)) ? EW'(MAX_EDGES) : EW'(off_rd_r);
    e_inc    = e_r + 1'b1;
    v_last   = (v_r == n_active - VW'(1));
    sacc     = {1'b0, sum_rd_r} + {1'b0, share_r};
    uacc     = {1'b0, base_r} + {1'b0, prod_r[RW+15:16]};
    diff     = (upd_r > old_r) ? upd_r - old_r : old_r - upd_r;
    dacc     = CW'(delta_r) + CW'(diff);
    iter_inc = iter_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    hw_nxt        = hw_r;
    e_nxt         = e_r;
    row_start_nxt = row_start_r;
    row_end_nxt   = row_end_r;
    init_nxt      = init_r;
    base_nxt      = base_r;
    share_nxt     = share_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    old_nxt       = old_r;
    upd_nxt       = upd_r;
    delta_nxt     = delta_r;
    iter_nxt      = iter_r;
    slot_nxt      = slot_r;
    inr_nxt       = inr_r;
    res_kind_nxt  = res_kind_r;
    res_iter_nxt  = res_iter_r;
    res_rank_nxt  = res_rank_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_iter_nxt  = out_iter_r;
    out_rank_nxt  = out_rank_r;
    pop           = 1'b0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    off_we  = 1'b0; off_wa  = '0; off_wd  = '0; off_re  = 1'b0; off_ra  = '0;
    tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd  = '0; tgt_re  = 1'b0; tgt_ra  = '0;
    rank_we = 1'b0; rank_wa = '0; rank_wd = '0; rank_re = 1'b0; rank_ra = '0;
    sum_we  = 1'b0; sum_wa  = '0; sum_wd  = '0; sum_re  = 1'b0; sum_ra  = '0;

    case (state_r)
      S_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          case (q_head.op)
            CMD_WR_OFFSET: begin
              off_we = 1'b1;
              off_wa = OAW'(q_head.slot);
              off_wd = q_head.datum;
            end
            CMD_WR_TARGET: begin
              tgt_we = 1'b1;
              tgt_wa = EAW'(q_head.slot);
              tgt_wd = q_head.datum;
            end
            CMD_RUN: begin
              div_start    = 1'b1;
              div_dividend = one_val;
              div_divisor  = DVW'(n_active);
              state_nxt    = S_W_INIT;
            end
            default: begin
              rank_re   = 1'b1;
              rank_ra   = VAW'(q_head.slot);
              slot_nxt  = q_head.slot;
              inr_nxt   = q_head.in_range;
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        // vertices outside the vertex count or beyond every run so far read as zero
        res_kind_nxt = KIND_RANK;
        res_iter_nxt = '0;
        res_rank_nxt = (inr_r && (32'(slot_r) < 32'(hw_r))) ? 32'(rank_rd_r) : '0;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_iter_nxt  = res_iter_r;
          out_rank_nxt  = res_rank_r;
          state_nxt     = S_IDLE;
        end
      end
      S_W_INIT: begin
        if (div_done) begin
          init_nxt     = div_q;
          div_start    = 1'b1;
          div_dividend = base_num;
          div_divisor  = DVW'(n_active);
          state_nxt    = S_W_BASE;
        end
      end
      S_W_BASE: begin
        if (div_done) begin
          base_nxt  = div_q;
          v_nxt     = '0;
          hw_nxt    = (hw_r > n_active) ? hw_r : n_active;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        rank_we = 1'b1;
        rank_wa = VAW'(v_r);
        rank_wd = init_r;
        if (v_last) begin
          v_nxt    = '0;
          iter_nxt = '0;
          if (cfg.limit == '0) begin
            res_kind_nxt = KIND_RUN;
            res_iter_nxt = '0;
            res_rank_nxt = '0;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_CLR;
          end
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      S_CLR: begin
        sum_we = 1'b1;
        sum_wa = VAW'(v_r);
        sum_wd = '0;
        if (v_last) begin
          v_nxt     = '0;
          delta_nxt = '0;
          off_re    = 1'b1;
          off_ra    = '0;
          state_nxt = S_OFF0;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      S_OFF0: begin
        row_start_nxt = clamp_rd;
        off_re        = 1'b1;
        off_ra        = OAW'(v_r + 1'b1);
        rank_re       = 1'b1;
        rank_ra       = VAW'(v_r);
        state_nxt     = S_SRC;
      end
      S_SRC: begin
        row_end_nxt = clamp_rd;
        e_nxt       = row_start_r;
        if (clamp_rd > row_start_r) begin
          div_start    = 1'b1;
          div_dividend = rank_rd_r;
          div_divisor  = DVW'(clamp_rd - row_start_r);
          state_nxt    = S_SHARE;
        end else begin
          state_nxt = S_NEXTV;
        end
      end
      S_SHARE: begin
        if (div_done) begin
          share_nxt = div_q;
          tgt_re    = 1'b1;
          tgt_ra    = EAW'(e_r);
          state_nxt = S_EDGE_B;
        end
      end
      S_EDGE_B: begin
        if (32'(tgt_rd_r) < 32'(n_active)) begin
          sum_re    = 1'b1;
          sum_ra    = VAW'(tgt_rd_r);
          t_nxt     = VAW'(tgt_rd_r);
          state_nxt = S_EDGE_C;
        end else begin
          e_nxt = e_inc;
          if (e_inc == row_end_r) begin
            state_nxt = S_NEXTV;
          end else begin
            tgt_re = 1'b1;
            tgt_ra = EAW'(e_inc);
          end
        end
      end
      S_EDGE_C: begin
        sum_we = 1'b1;
        sum_wa = t_r;
        sum_wd = sacc[RW] ? '1 : sacc[RW-1:0];
        e_nxt  = e_inc;
        if (e_inc == row_end_r) begin
          state_nxt = S_NEXTV;
        end else begin
          tgt_re    = 1'b1;
          tgt_ra    = EAW'(e_inc);
          state_nxt = S_EDGE_B;
        end
      end
      S_NEXTV: begin
        row_start_nxt = row_end_r;
        if (v_last) begin
          v_nxt     = '0;
          sum_re    = 1'b1;
          sum_ra    = '0;
          rank_re   = 1'b1;
          rank_ra   = '0;
          state_nxt = S_UPD_A;
        end else begin
          v_nxt     = v_r + 1'b1;
          off_re    = 1'b1;
          off_ra    = OAW'(v_r + VW'(2));
          rank_re   = 1'b1;
          rank_ra   = VAW'(v_r + 1'b1);
          state_nxt = S_SRC;
        end
      end
      S_UPD_A: begin
        prod_nxt  = (RW+16)'(sum_rd_r) * (RW+16)'(cfg.damping);
        old_nxt   = rank_rd_r;
        state_nxt = S_UPD_B;
      end
      S_UPD_B: begin
        upd_nxt   = uacc[RW] ? '1 : uacc[RW-1:0];
        state_nxt = S_UPD_C;
      end
      S_UPD_C: begin
        rank_we   = 1'b1;
        rank_wa   = VAW'(v_r);
        rank_wd   = upd_r;
        delta_nxt = (dacc > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : dacc[31:0];
        if (v_last) begin
          state_nxt = S_ITER;
        end else begin
          v_nxt     = v_r + 1'b1;
          sum_re    = 1'b1;
          sum_ra    = VAW'(v_r + 1'b1);
          rank_re   = 1'b1;
          rank_ra   = VAW'(v_r + 1'b1);
          state_nxt = S_UPD_A;
        end
      end
      S_ITER: begin
        iter_nxt = iter_inc;
        v_nxt    = '0;
        if ((delta_r < cfg.threshold) || (iter_inc >= cfg.limit)) begin
          res_kind_nxt = KIND_RUN;
          res_iter_nxt = iter_inc;
          res_rank_nxt = '0;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    e_r         <= e_nxt;
    row_start_r <= row_start_nxt;
    row_end_r   <= row_end_nxt;
    init_r      <= init_nxt;
    base_r      <= base_nxt;
    share_r     <= share_nxt;
    t_r         <= t_nxt;
    prod_r      <= prod_nxt;
    old_r       <= old_nxt;
    upd_r       <= upd_nxt;
    delta_r     <= delta_nxt;
    iter_r      <= iter_nxt;
    slot_r      <= slot_nxt;
    inr_r       <= inr_nxt;
    res_kind_r  <= res_kind_nxt;
    res_iter_r  <= res_iter_nxt;
    res_rank_r  <= res_rank_nxt;
    out_kind_r  <= out_kind_nxt;
    out_iter_r  <= out_iter_nxt;
    out_rank_r  <= out_rank_nxt;
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    if (off_re) begin
      off_rd_r <= off_mem[off_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    if (tgt_re) begin
      tgt_rd_r <= tgt_mem[tgt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (rank_re) begin
      rank_rd_r <= rank_mem[rank_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (sum_re) begin
      sum_rd_r <= sum_mem[sum_ra];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_iterations_done = out_iter_r;
  assign out_rank_value      = out_rank_r;

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_W_INIT || state_r == S_W_BASE || state_r == S_SHARE))
    else $error("divider finished with no one waiting");

  a_edge_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_B) |-> (e_r >= row_start_r && e_r < row_end_r))
    else $error("edge walk left its row");

  a_scatter_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_C) |-> (32'(t_r) < 32'(n_active)))
    else $error("scatter to a vertex outside the graph");

endmodule
`default_nettype wire

// File: rtl/pagerank_power_iteration.sv
`default_nettype none
// PageRank power iteration over a CSR graph in unsigned Q1.31 fixed point. Words
// are taken one a cycle, while the queue is not full, into a four-deep command
// queue; the engine behind it applies an offset or target write as it pops the
// word, and answers a rank read through its read and emit states. A run first
// forms the initial rank and the base term with two serial divisions and writes
// the initial rank to every vertex; each iteration then clears the sums, walks
// every row (a row with edges has its share formed by the serial divider, a
// dangling row is passed over), scatters the share to each edge whose target
// lies inside the graph, and then updates every rank. Results wait in an output
// register, so the queue keeps filling while one is unread.
module pagerank_power_iteration
  import prpi_pkg::*;
#(
  parameter int MAX_VERTICES   = 1024,
  parameter int MAX_EDGES      = 8192,
  parameter int RANK_FRAC_BITS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [13:0] in_slot,
  input  wire logic [13:0] in_datum,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_iterations_done,
  output logic [31:0]      out_rank_value
);

  localparam int VW = $clog2(MAX_VERTICES + 1);

  logic [10:0]   vertex_count_r, vertex_count_nxt;
  logic [15:0]   damping_r, damping_nxt;
  logic [31:0]   threshold_r, threshold_nxt;
  logic [15:0]   iter_limit_r, iter_limit_nxt;
  logic          wr_en;
  logic [VW-1:0] n_active;
  prpi_cfg_t     cfg;
  prpi_qstat_t   qstat;
  prpi_cmd_t     q_head, entry;
  logic          push, pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    damping_nxt      = damping_r;
    threshold_nxt    = threshold_r;
    iter_limit_nxt   = iter_limit_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_VERTEX_COUNT: vertex_count_nxt = pwdata[10:0];
        REG_DAMPING:      damping_nxt      = pwdata[15:0];
        REG_THRESHOLD:    threshold_nxt    = pwdata;
        REG_ITER_LIMIT:   iter_limit_nxt   = pwdata[15:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 11'd1;
      damping_r      <= 16'd55706;
      threshold_r    <= 32'd2147;
      iter_limit_r   <= 16'd100;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      damping_r      <= damping_nxt;
      threshold_r    <= threshold_nxt;
      iter_limit_r   <= iter_limit_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VERTEX_COUNT: prdata = 32'(vertex_count_r);
      REG_DAMPING:      prdata = 32'(damping_r);
      REG_THRESHOLD:    prdata = threshold_r;
      REG_ITER_LIMIT:   prdata = 32'(iter_limit_r);
      default:          prdata = '0;
    endcase
  end

  // zero counts as one vertex, oversize counts clamp to the store
  always_comb begin
    if (vertex_count_r == '0) begin
      n_active = VW'(1);
    end else if (32'(vertex_count_r) > 32'(MAX_VERTICES)) begin
      n_active = VW'(MAX_VERTICES);
    end else begin
      n_active = VW'(vertex_count_r);
    end
  end

  assign cfg.damping   = damping_r;
  assign cfg.threshold = threshold_r;
  assign cfg.limit     = iter_limit_r;

  prpi_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .VW           (VW)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_slot    (in_slot),
    .in_datum   (in_datum),
    .n_active   (n_active),
    .qstat      (qstat),
    .push       (push),
    .entry      (entry)
  );

  prpi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (q_head),
    .qstat     (qstat)
  );

  prpi_engine #(
    .MAX_VERTICES   (MAX_VERTICES),
    .MAX_EDGES      (MAX_EDGES),
    .RANK_FRAC_BITS (RANK_FRAC_BITS),
    .VW             (VW)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_head              (q_head),
    .qstat               (qstat),
    .pop                 (pop),
    .n_active            (n_active),
    .cfg                 (cfg),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_iterations_done (out_iterations_done),
    .out_rank_value      (out_rank_value)
  );

endmodule
`default_nettype wire
